// ----- src/mmas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_pkg
// Shared types, constants and helpers for the small dense matrix engine.
// ----------------------------------------------------------------------------
package mmas_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 4;
    localparam int CIDX_W = 2;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + CNT_W + 1;

    // request codes
    localparam logic [1:0] REQ_WR_A    = 2'd0;
    localparam logic [1:0] REQ_WR_B    = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // operation codes
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_OP_MODE   = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last_element;
    } t_out_item;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              rd_en;
        logic              first;
        logic              load_out;
        logic [1:0]        op;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_stat;

    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] r);
        if (r == '0) begin
            return DIM_W'(1);
        end else if (int'(r) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(r);
    endfunction

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-VAL_W:0] hi;
        hi = v[ACC_W-1:VAL_W-1];
        if (hi == '0 || hi == '1) begin
            return v[VAL_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

endpackage

// ----- src/mmas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mmas_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_ctrl
// Configuration registers and element sequencer for the matrix engine.
// ----------------------------------------------------------------------------
module mmas_ctrl
    import mmas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    input  logic              i_out_stall,
    input  t_stat             i_stat,
    output t_cmd              o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic [IDX_W-1:0]  o_row,
    output logic [IDX_W-1:0]  o_col,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_rows, r_inner, r_cols;
    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;

    logic             add_sub;
    logic [DIM_W-1:0] nr, nk, nc, nk_eff;
    logic             last_i, last_j, last_k, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CFG_W'(1);
            r_inner <= CFG_W'(1);
            r_cols  <= CFG_W'(1);
            r_mode  <= OP_MUL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:    r_rows  <= i_cfg_data;
                CFG_INNER_DIM: r_inner <= i_cfg_data;
                CFG_COLS_B:    r_cols  <= i_cfg_data;
                CFG_OP_MODE:   r_mode  <= i_cfg_data[1:0];
            endcase
        end
    end

    assign add_sub = (r_mode == OP_ADD) || (r_mode == OP_SUB);
    assign nr      = dim_of(r_rows);
    assign nk      = dim_of(r_inner);
    assign nc      = add_sub ? nk : dim_of(r_cols);
    assign nk_eff  = add_sub ? DIM_W'(1) : nk;
    assign last_i  = (DIM_W'(r_i) + DIM_W'(1)) == nr;
    assign last_j  = (DIM_W'(r_j) + DIM_W'(1)) == nc;
    assign last_k  = (DIM_W'(r_k) + DIM_W'(1)) == nk_eff;
    assign accept  = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_i            = r_i;
        n_j            = r_j;
        n_k            = r_k;
        o_cmd          = '0;
        o_cmd.op       = r_mode;
        o_cmd.first    = (r_k == '0);
        if (add_sub) begin
            o_cmd.rd_addr_a = mk_addr(r_i, r_j);
            o_cmd.rd_addr_b = mk_addr(r_i, r_j);
        end else begin
            o_cmd.rd_addr_a = mk_addr(r_i, r_k);
            o_cmd.rd_addr_b = mk_addr(r_k, r_j);
        end
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_a = accept && (i_req_type == REQ_WR_A);
                o_cmd.wr_b = accept && (i_req_type == REQ_WR_B);
                if (accept && (i_req_type == REQ_COMPUTE)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (last_k) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (last_i && last_j) begin
                        n_state = S_IDLE;
                    end else if (last_j) begin
                        n_j     = '0;
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_READ;
                    end else begin
                        n_j     = r_j + CNT_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_row       = IDX_W'(r_i);
    assign o_col       = IDX_W'(r_j);
    assign o_last      = last_i && last_j;

endmodule

// ----- src/mmas_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_dp
// Element stores, multiply, add or subtract stage, accumulator and saturating output.
// ----------------------------------------------------------------------------
module mmas_dp
    import mmas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_wr_row,
    input  logic [IDX_W-1:0]  i_wr_col,
    input  logic [VAL_W-1:0]  i_wr_data,
    output t_stat             o_stat,
    output logic [VAL_W-1:0]  o_value
);

    logic [DEPTH-1:0]         r_a_vld, r_b_vld;
    logic                     r_va1, r_vb1;
    logic                     r_v1, r_first1, r_v2, r_first2;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [VAL_W-1:0]         r_out_value;

    logic                     wr_ok, we_a, we_b;
    logic [ADDR_W-1:0]        waddr;
    logic [VAL_W-1:0]         rd_a, rd_b;
    logic signed [VAL_W-1:0]  a, b;
    logic                     is_add, is_sub;

    assign wr_ok  = (int'(i_wr_row) < MAX_DIM) && (int'(i_wr_col) < MAX_DIM);
    assign we_a   = i_cmd.wr_a && wr_ok;
    assign we_b   = i_cmd.wr_b && wr_ok;
    assign waddr  = mk_addr(i_wr_row, i_wr_col);
    assign is_add = (i_cmd.op == OP_ADD);
    assign is_sub = (i_cmd.op == OP_SUB);

    mmas_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_wr_data),
        .i_raddr (i_cmd.rd_addr_a),
        .o_rdata (rd_a)
    );

    mmas_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_wr_data),
        .i_raddr (i_cmd.rd_addr_b),
        .o_rdata (rd_b)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (we_a) begin
                r_a_vld[waddr] <= 1'b1;
            end
            if (we_b) begin
                r_b_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va1 <= r_a_vld[i_cmd.rd_addr_a];
        r_vb1 <= r_b_vld[i_cmd.rd_addr_b];
    end

    assign a = r_va1 ? signed'(rd_a) : '0;
    assign b = r_vb1 ? signed'(rd_b) : '0;

    always_comb begin
        if (is_add) begin
            n_prod = PROD_W'(a) + PROD_W'(b);
        end else if (is_sub) begin
            n_prod = PROD_W'(a) - PROD_W'(b);
        end else begin
            n_prod = a * b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_v2     <= 1'b0;
            r_first2 <= 1'b0;
        end else begin
            r_v1     <= i_cmd.rd_en;
            r_first1 <= i_cmd.first;
            r_v2     <= r_v1;
            r_first2 <= r_first1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_v2) begin
            r_acc <= r_first2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.load_out) begin
            r_out_value <= (is_add || is_sub) ? sat32(r_acc) : sat32(r_acc >>> FRAC_BITS);
        end
    end

    assign o_stat.busy = r_v1 || r_v2;
    assign o_value     = r_out_value;

endmodule

// ----- src/matrix_multiply_add_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_add_sub
// Dense matrix engine on signed Q16.16 elements: loads elements of A and B,
// then emits A*B, A+B or A-B in row-major order with saturation.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------------
//   input   | i_in_valid | o_in_stall  | i_in_item  (t_in_item)
//   output  | o_out_valid| i_out_stall | o_out_item (t_out_item)
//
// load items are accepted while idle and can follow back to back
// a compute item, for each result element, reads inner_dim product terms (one
// for add or subtract), drains the product pipeline, then holds the element
// on the output until taken; terms come through one read port per store
// input is stalled from a compute item until its last element is taken
// reset clears the stores at once through per-entry valid bits
// ----------------------------------------------------------------------------
module matrix_multiply_add_sub
    import mmas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    input  logic              i_out_stall
);

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] row, col;
    logic             last;
    logic [VAL_W-1:0] value;

    mmas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_item.req_type),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_row       (row),
        .o_col       (col),
        .o_last      (last)
    );

    mmas_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_wr_row  (i_in_item.row_index),
        .i_wr_col  (i_in_item.col_index),
        .i_wr_data (i_in_item.element_value),
        .o_stat    (stat),
        .o_value   (value)
    );

    assign o_out_item.out_row      = row;
    assign o_out_item.out_col      = col;
    assign o_out_item.out_value    = signed'(value);
    assign o_out_item.last_element = last;

endmodule

// ----- src/mmas_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmas_chk
// Port-level checks for the matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
module mmas_chk
    import mmas_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_item  i_in_item,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // no new items while a result is pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.req_type == REQ_COMPUTE) |=> o_in_stall)
        else $error("compute item did not stall input");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last_element) |=>
            (!o_in_stall && !o_out_valid))
        else $error("engine not free after last element");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs active after reset");

endmodule

bind matrix_multiply_add_sub mmas_chk u_chk (.*);
